FILE: design/sqvg_pkg.sv
// Package for the sprite quad vertex generator: widths, payload structs,
// CORDIC arctangent table and the alpha premultiply helper. No dependencies.
package sqvg_pkg;

  localparam int ANGLE_BITS       = 16;
  localparam int TRIG_FRAC_BITS   = 16;
  localparam int CORDIC_FRAC      = 30;
  localparam int CORDIC_STEPS     = 24;
  localparam int CORDIC_PER_STAGE = 3;
  localparam int CORDIC_STAGES    = CORDIC_STEPS / CORDIC_PER_STAGE;
  localparam int CW               = 33;                     // CORDIC x/y width
  localparam int ZW               = 26;                     // residual angle width
  localparam int TW               = TRIG_FRAC_BITS + 2;     // cos/sin width
  localparam int TRIG_SH          = CORDIC_FRAC - TRIG_FRAC_BITS;
  localparam int LW               = 33;                     // corner offset width
  localparam int PW               = LW + TW;                // product width
  localparam int RW               = PW + 2 - TRIG_FRAC_BITS; // rounded sum width

  localparam logic [23:0]          PHASE_MASK  = 24'hFFFFFF << (24 - ANGLE_BITS);
  localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic [7:0]           ALPHA_OPAQUE = 8'hFF;
  localparam logic [15:0]          ROUND_BIAS  = 16'd127;
  localparam logic [15:0]          UV_MAX      = 16'hFFFF;
  localparam logic [31:0]          POS_MAX     = 32'h7FFF_FFFF;
  localparam logic [31:0]          POS_MIN     = 32'h8000_0000;

  typedef enum logic [1:0] {
    CORNER_TL = 2'd0,
    CORNER_TR = 2'd1,
    CORNER_BR = 2'd2,
    CORNER_BL = 2'd3
  } corner_e;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_e;

  typedef struct packed {
    logic signed [31:0] dst_x;
    logic signed [31:0] dst_y;
    logic signed [31:0] dst_w;
    logic signed [31:0] dst_h;
    logic [31:0]        uv_start;
    logic [31:0]        uv_size;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [15:0] rotation;
    logic [1:0]         effects;
    logic [31:0]        color;
  } sqvg_in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic [31:0]        vertex_color;
    logic [1:0]         corner;
    logic               last;
  } sqvg_out_t;

  // per-sprite geometry that rides alongside the CORDIC
  typedef struct packed {
    logic signed [LW-1:0] cx;
    logic signed [LW-1:0] cy;
    logic signed [LW-1:0] lxa;   // left corner x offset from pivot
    logic signed [LW-1:0] lxb;   // right
    logic signed [LW-1:0] lya;   // top
    logic signed [LW-1:0] lyb;   // bottom
    logic [15:0]          u0;
    logic [15:0]          u1;
    logic [15:0]          v0;
    logic [15:0]          v1;
    logic [31:0]          col;
  } geo_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic [1:0]           q;
    logic                 zero;  // reduced angle exactly zero on entry
  } cordic_t;

  // atan(2^-i) in 2^-24 turn
  function automatic logic signed [ZW-1:0] atan_lut(int i);
    logic signed [ZW-1:0] r;
    case (i)
      0:       r = 26'sd2097152;
      1:       r = 26'sd1238021;
      2:       r = 26'sd654136;
      3:       r = 26'sd332050;
      4:       r = 26'sd166669;
      5:       r = 26'sd83416;
      6:       r = 26'sd41718;
      7:       r = 26'sd20860;
      8:       r = 26'sd10430;
      9:       r = 26'sd5215;
      10:      r = 26'sd2608;
      11:      r = 26'sd1304;
      12:      r = 26'sd652;
      13:      r = 26'sd326;
      14:      r = 26'sd163;
      15:      r = 26'sd81;
      16:      r = 26'sd41;
      17:      r = 26'sd20;
      18:      r = 26'sd10;
      19:      r = 26'sd5;
      20:      r = 26'sd3;
      21:      r = 26'sd1;
      22:      r = 26'sd1;
      default: r = 26'sd0;
    endcase
    return r;
  endfunction

  // (c*a + 127) / 255 via x/255 = (x + (x>>8) + 1) >> 8, exact for x up to 65534
  function automatic logic [7:0] premul_ch(logic [7:0] c, logic [7:0] a);
    logic [15:0] p;
    logic [16:0] s;
    p = 16'(c) * 16'(a) + ROUND_BIAS;
    s = {1'b0, p} + {9'b0, p[15:8]} + 17'd1;
    return s[15:8];
  endfunction

endpackage

FILE: design/sprite_quad_vertex_gen_unit.sv
// Top level of the sprite quad vertex generator: prep stage, CORDIC pipeline,
// vertex back end. Depends on sqvg_pkg, sqvg_prep, sqvg_cordic, sqvg_vertex.
//
//   channel | dir | handshake          | word
//   in      | in  | in_valid_i/stall_o | sqvg_in_t, one sprite
//   out     | out | out_valid_o/stall_i| sqvg_out_t, one vertex
//
// Pipeline: 1 prep + 8 CORDIC + 1 sequencer + 1 multiply + 1 output = 12 register
// stages. The corner sequencer emits the four vertices of a sprite one by one and
// takes the next sprite as it emits the last; one vertex per cycle on the single
// output channel while it is not stalled. Up to eleven sprites can be in flight.
// Reset clears the valid bits and the corner counter; payload registers are not reset.
// A stall on the output backs up stage by stage; bubbles are squeezed out.
module sprite_quad_vertex_gen_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sqvg_pkg::sqvg_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sqvg_pkg::sqvg_out_t out_data_o
);
  import sqvg_pkg::*;

  logic    prep_ready, prep_valid, cor_ready, cor_valid, vtx_ready;
  geo_t    prep_geo, cor_geo;
  cordic_t prep_cor, cor_res;

  sqvg_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (prep_ready),
    .data_i  (in_data_i),
    .valid_o (prep_valid),
    .ready_i (cor_ready),
    .geo_o   (prep_geo),
    .cor_o   (prep_cor)
  );

  sqvg_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prep_valid),
    .ready_o (cor_ready),
    .cor_i   (prep_cor),
    .geo_i   (prep_geo),
    .valid_o (cor_valid),
    .ready_i (vtx_ready),
    .cor_o   (cor_res),
    .geo_o   (cor_geo)
  );

  sqvg_vertex u_vertex (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (cor_valid),
    .ready_o     (vtx_ready),
    .cor_i       (cor_res),
    .geo_i       (cor_geo),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  assign in_stall_o = !prep_ready;

`ifndef SYNTH
  // last flags exactly the bottom-left corner
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last == (out_data_o.corner == CORNER_BL)))
    else $error("last flag does not match corner");

  // corners of one sprite leave in order
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !out_data_o.last) |=>
      (!out_valid_o || (out_data_o.corner == 2'($past(out_data_o.corner) + 2'd1))))
    else $error("corner sequence broken");

  // a fresh sprite always starts at the top-left corner
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_data_o.last) |=>
      (!out_valid_o || (out_data_o.corner == CORNER_TL)))
    else $error("sprite does not start at top-left");
`endif

endmodule

FILE: design/sqvg_prep.sv
// Input stage: corner offsets, pivot, UV ends with flips, premultiplied color,
// quadrant split of the angle. Depends on sqvg_pkg.
module sqvg_prep (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  sqvg_pkg::sqvg_in_t data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output sqvg_pkg::geo_t   geo_o,
  output sqvg_pkg::cordic_t cor_o
);
  import sqvg_pkg::*;

  logic        valid_q;
  geo_t        geo_q, geo_d;
  cordic_t     cor_q, cor_d;
  logic [23:0] phase, ph_rnd, zr;
  logic [1:0]  q;
  logic [16:0] us, vs;
  logic [15:0] u0, u1, v0, v1;
  logic [7:0]  a;
  logic signed [LW-1:0] ox, oy;

  always_comb begin
    phase  = {data_i.rotation, 8'h00} & PHASE_MASK;
    ph_rnd = phase + 24'h200000;
    q      = ph_rnd[23:22];
    zr     = phase - {q, 22'b0};

    cor_d.x    = CORDIC_GAIN;
    cor_d.y    = '0;
    cor_d.z    = {{(ZW-24){zr[23]}}, zr};
    cor_d.q    = q;
    cor_d.zero = (zr == 24'd0);

    ox = {data_i.origin_x[31], data_i.origin_x};
    oy = {data_i.origin_y[31], data_i.origin_y};
    geo_d.cx  = {data_i.dst_x[31], data_i.dst_x} + ox;
    geo_d.cy  = {data_i.dst_y[31], data_i.dst_y} + oy;
    geo_d.lxa = -ox;
    geo_d.lya = -oy;
    geo_d.lxb = {data_i.dst_w[31], data_i.dst_w} - ox;
    geo_d.lyb = {data_i.dst_h[31], data_i.dst_h} - oy;

    u0 = data_i.uv_start[15:0];
    v0 = data_i.uv_start[31:16];
    us = {1'b0, u0} + {1'b0, data_i.uv_size[15:0]};
    vs = {1'b0, v0} + {1'b0, data_i.uv_size[31:16]};
    u1 = us[16] ? UV_MAX : us[15:0];
    v1 = vs[16] ? UV_MAX : vs[15:0];
    geo_d.u0 = data_i.effects[0] ? u1 : u0;
    geo_d.u1 = data_i.effects[0] ? u0 : u1;
    geo_d.v0 = data_i.effects[1] ? v1 : v0;
    geo_d.v1 = data_i.effects[1] ? v0 : v1;

    a = data_i.color[31:24];
    if (a == ALPHA_OPAQUE) begin
      geo_d.col = data_i.color;
    end else begin
      geo_d.col = {a, premul_ch(data_i.color[23:16], a),
                   premul_ch(data_i.color[15:8], a), premul_ch(data_i.color[7:0], a)};
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign geo_o   = geo_q;
  assign cor_o   = cor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      geo_q <= geo_d;
      cor_q <= cor_d;
    end
  end

endmodule

FILE: design/sqvg_cordic.sv
// Pipelined rotation-mode CORDIC, a few iterations per register stage; the
// sprite geometry travels alongside. Depends on sqvg_pkg.
module sqvg_cordic (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  sqvg_pkg::cordic_t cor_i,
  input  sqvg_pkg::geo_t    geo_i,
  output logic              valid_o,
  input  logic              ready_i,
  output sqvg_pkg::cordic_t cor_o,
  output sqvg_pkg::geo_t    geo_o
);
  import sqvg_pkg::*;

  logic    v_q   [CORDIC_STAGES];
  cordic_t c_q   [CORDIC_STAGES];
  geo_t    g_q   [CORDIC_STAGES];
  cordic_t c_nxt [CORDIC_STAGES];
  logic    rdy   [CORDIC_STAGES+1];

  assign rdy[CORDIC_STAGES] = ready_i;
  assign ready_o = rdy[0];
  assign valid_o = v_q[CORDIC_STAGES-1];
  assign cor_o   = c_q[CORDIC_STAGES-1];
  assign geo_o   = g_q[CORDIC_STAGES-1];

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
    cordic_t src;
    geo_t    gsrc;
    logic    vsrc;

    if (k == 0) begin : g_first
      assign src  = cor_i;
      assign gsrc = geo_i;
      assign vsrc = valid_i;
    end else begin : g_rest
      assign src  = c_q[k-1];
      assign gsrc = g_q[k-1];
      assign vsrc = v_q[k-1];
    end

    always_comb begin
      cordic_t t;
      logic signed [CW-1:0] dx, dy;
      t = src;
      for (int j = 0; j < CORDIC_PER_STAGE; j++) begin
        dx = $signed(t.x) >>> (k * CORDIC_PER_STAGE + j);
        dy = $signed(t.y) >>> (k * CORDIC_PER_STAGE + j);
        if (!t.z[ZW-1]) begin
          t.x = t.x - dy;
          t.y = t.y + dx;
          t.z = t.z - atan_lut(k * CORDIC_PER_STAGE + j);
        end else begin
          t.x = t.x + dy;
          t.y = t.y - dx;
          t.z = t.z + atan_lut(k * CORDIC_PER_STAGE + j);
        end
      end
      c_nxt[k] = t;
    end

    assign rdy[k] = !v_q[k] || rdy[k+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_q[k] <= vsrc;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && vsrc) begin
        c_q[k] <= c_nxt[k];
        g_q[k] <= gsrc;
      end
    end
  end

endmodule

FILE: design/sqvg_vertex.sv
// Vertex back end: trig rounding and quadrant fold, corner sequencer,
// multiply stage, round/translate/saturate output register. Depends on sqvg_pkg.
module sqvg_vertex (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  sqvg_pkg::cordic_t   cor_i,
  input  sqvg_pkg::geo_t      geo_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sqvg_pkg::sqvg_out_t out_data_o
);
  import sqvg_pkg::*;

  // trig fold
  logic signed [CW-1:0] xr, yr;
  logic signed [TW-1:0] c_r, s_r, co_d, si_d;

  // corner sequencer
  logic                 busy_q;
  corner_e              cnt_q;
  geo_t                 g_q;
  logic signed [TW-1:0] co_q, si_q;
  logic                 sel_r, sel_b, emit;
  logic signed [LW-1:0] lx, ly;

  // multiply stage
  logic                 m_valid_q, m_rdy;
  logic signed [PW-1:0] m_pxa_q, m_pxb_q, m_pya_q, m_pyb_q;
  logic signed [LW-1:0] m_cx_q, m_cy_q;
  logic [15:0]          m_u_q, m_v_q;
  logic [31:0]          m_col_q;
  corner_e              m_cnt_q;

  // output stage
  logic                 out_valid_q, o_rdy;
  sqvg_out_t            out_q;
  logic signed [PW:0]   sum_x, sum_y;
  logic signed [RW-1:0] rx, ry;
  logic [31:0]          pos_x, pos_y;

  always_comb begin
    xr  = cor_i.x + (CW'(1) <<< (TRIG_SH - 1));
    yr  = cor_i.y + (CW'(1) <<< (TRIG_SH - 1));
    c_r = xr[TRIG_SH+TW-1:TRIG_SH];
    s_r = yr[TRIG_SH+TW-1:TRIG_SH];
    if (cor_i.zero) begin
      c_r = TW'(1) <<< TRIG_FRAC_BITS;
      s_r = '0;
    end
    case (cor_i.q)
      QUAD_1: begin co_d = -s_r; si_d = c_r;  end
      QUAD_2: begin co_d = -c_r; si_d = -s_r; end
      QUAD_3: begin co_d = s_r;  si_d = -c_r; end
      default: begin co_d = c_r; si_d = s_r;  end
    endcase
  end

  assign o_rdy   = !out_valid_q || !out_stall_i;
  assign m_rdy   = !m_valid_q || o_rdy;
  assign emit    = busy_q && m_rdy;
  assign ready_o = !busy_q || (emit && (cnt_q == CORNER_BL));

  assign sel_r = (cnt_q == CORNER_TR) || (cnt_q == CORNER_BR);
  assign sel_b = (cnt_q == CORNER_BR) || (cnt_q == CORNER_BL);
  assign lx    = sel_r ? g_q.lxb : g_q.lxa;
  assign ly    = sel_b ? g_q.lyb : g_q.lya;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= CORNER_TL;
    end else if (ready_o) begin
      busy_q <= valid_i;
      cnt_q  <= CORNER_TL;
    end else if (emit) begin
      cnt_q  <= corner_e'(cnt_q + 2'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      g_q  <= geo_i;
      co_q <= co_d;
      si_q <= si_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (m_rdy) begin
      m_valid_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      m_pxa_q <= PW'(lx) * PW'(co_q);
      m_pxb_q <= PW'(ly) * PW'(si_q);
      m_pya_q <= PW'(lx) * PW'(si_q);
      m_pyb_q <= PW'(ly) * PW'(co_q);
      m_cx_q  <= g_q.cx;
      m_cy_q  <= g_q.cy;
      m_u_q   <= sel_r ? g_q.u1 : g_q.u0;
      m_v_q   <= sel_b ? g_q.v1 : g_q.v0;
      m_col_q <= g_q.col;
      m_cnt_q <= cnt_q;
    end
  end

  always_comb begin
    sum_x = (PW+1)'(m_pxa_q) - (PW+1)'(m_pxb_q) + ((PW+1)'(1) <<< (TRIG_FRAC_BITS - 1));
    sum_y = (PW+1)'(m_pya_q) + (PW+1)'(m_pyb_q) + ((PW+1)'(1) <<< (TRIG_FRAC_BITS - 1));
    rx = RW'($signed(sum_x[PW:TRIG_FRAC_BITS])) + RW'(m_cx_q);
    ry = RW'($signed(sum_y[PW:TRIG_FRAC_BITS])) + RW'(m_cy_q);
    // in range when all bits above bit 31 match the sign
    if ((rx[RW-1:31] == '0) || (rx[RW-1:31] == '1)) begin
      pos_x = rx[31:0];
    end else begin
      pos_x = rx[RW-1] ? POS_MIN : POS_MAX;
    end
    if ((ry[RW-1:31] == '0) || (ry[RW-1:31] == '1)) begin
      pos_y = ry[31:0];
    end else begin
      pos_y = ry[RW-1] ? POS_MIN : POS_MAX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (o_rdy) begin
      out_valid_q <= m_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_rdy && m_valid_q) begin
      out_q.pos_x        <= pos_x;
      out_q.pos_y        <= pos_y;
      out_q.tex_u        <= m_u_q;
      out_q.tex_v        <= m_v_q;
      out_q.vertex_color <= m_col_q;
      out_q.corner       <= m_cnt_q;
      out_q.last         <= (m_cnt_q == CORNER_BL);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: dv/sprite_quad_vertex_gen_unit_test.sv
// Testbench for sprite_quad_vertex_gen_unit: drives sprites, predicts the four
// vertices of each and checks every output word. Depends on sqvg_pkg.
module sprite_quad_vertex_gen_unit_test;
  import sqvg_pkg::*;

  class vertex_board;
    sqvg_out_t pending[$];
    int errors;

    static function logic [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
    endfunction

    static function logic [7:0] blend(logic [7:0] c, logic [7:0] a);
      int unsigned p;
      p = (c * a + 127) / 255;
      return p[7:0];
    endfunction

    static function void trig(logic [23:0] phase, output longint co, output longint si);
      logic [1:0] q;
      logic [23:0] zr;
      longint z, x, y, dx, dy, c, s;
      longint angles[24] = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718,
        20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0};
      q = 2'((phase + 24'h200000) >> 22);
      zr = phase - {q, 22'd0};
      z = zr;
      if (z >= 64'h800000) z -= 64'h1000000;
      if (z == 0) begin
        c = 64'sd1 << TRIG_FRAC_BITS;
        s = 0;
      end else begin
        x = 652032874;
        y = 0;
        for (int i = 0; i < 24; i++) begin
          dx = y >>> i;
          dy = x >>> i;
          if (z >= 0) begin
            x -= dx; y += dy; z -= angles[i];
          end else begin
            x += dx; y -= dy; z += angles[i];
          end
        end
        c = (x + (64'sd1 << 13)) >>> 14;
        s = (y + (64'sd1 << 13)) >>> 14;
      end
      case (q)
        2'd1: begin co = -s; si = c; end
        2'd2: begin co = -c; si = -s; end
        2'd3: begin co = s; si = -c; end
        default: begin co = c; si = s; end
      endcase
    endfunction

    function void note_sprite(sqvg_in_t d);
      longint lx[4], ly[4], cx, cy, co, si, px, py, ox, oy;
      logic [16:0] ue, ve;
      logic [15:0] u0, u1, v0, v1, t;
      logic [23:0] phase;
      logic [31:0] col;
      sqvg_out_t v;
      ox = d.origin_x;
      oy = d.origin_y;
      col = d.color;
      if (col[31:24] != 8'hFF)
        col = {col[31:24], blend(col[23:16], col[31:24]), blend(col[15:8], col[31:24]),
               blend(col[7:0], col[31:24])};
      u0 = d.uv_start[15:0];
      v0 = d.uv_start[31:16];
      ue = u0 + d.uv_size[15:0];
      ve = v0 + d.uv_size[31:16];
      u1 = ue[16] ? 16'hFFFF : ue[15:0];
      v1 = ve[16] ? 16'hFFFF : ve[15:0];
      if (d.effects[0]) begin t = u0; u0 = u1; u1 = t; end
      if (d.effects[1]) begin t = v0; v0 = v1; v1 = t; end
      lx[0] = -ox; lx[1] = longint'(d.dst_w) - ox; lx[2] = lx[1]; lx[3] = -ox;
      ly[0] = -oy; ly[1] = -oy; ly[2] = longint'(d.dst_h) - oy; ly[3] = ly[2];
      cx = longint'(d.dst_x) + ox;
      cy = longint'(d.dst_y) + oy;
      phase = {d.rotation, 8'd0} & PHASE_MASK;
      co = 0;
      si = 0;
      if (phase != 0) trig(phase, co, si);
      for (int i = 0; i < 4; i++) begin
        if (phase == 0) begin
          px = cx + lx[i];
          py = cy + ly[i];
        end else begin
          px = cx + ((lx[i] * co - ly[i] * si + 32768) >>> 16);
          py = cy + ((lx[i] * si + ly[i] * co + 32768) >>> 16);
        end
        v.pos_x = clamp32(px);
        v.pos_y = clamp32(py);
        v.tex_u = (i == 0 || i == 3) ? u0 : u1;
        v.tex_v = (i < 2) ? v0 : v1;
        v.vertex_color = col;
        v.corner = corner_e'(i);
        v.last = (i == 3);
        pending.insert(pending.size(), v);
      end
    endfunction

    function void check_vertex(sqvg_out_t a);
      sqvg_out_t e;
      if (pending.size() == 0) begin
        $error("unexpected vertex word %h", a);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.pos_x !== e.pos_x) begin
        $error("pos_x exp %h got %h", e.pos_x, a.pos_x); errors++; end
      if (a.pos_y !== e.pos_y) begin
        $error("pos_y exp %h got %h", e.pos_y, a.pos_y); errors++; end
      if (a.tex_u !== e.tex_u) begin
        $error("tex_u exp %h got %h", e.tex_u, a.tex_u); errors++; end
      if (a.tex_v !== e.tex_v) begin
        $error("tex_v exp %h got %h", e.tex_v, a.tex_v); errors++; end
      if (a.vertex_color !== e.vertex_color) begin
        $error("vertex_color exp %h got %h", e.vertex_color, a.vertex_color); errors++; end
      if (a.corner !== e.corner) begin
        $error("corner exp %h got %h", e.corner, a.corner); errors++; end
      if (a.last !== e.last) begin
        $error("last exp %h got %h", e.last, a.last); errors++; end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic in_valid_i = 0, out_stall_i = 1;
  logic in_stall_o, out_valid_o;
  sqvg_in_t in_data_i = '0;
  sqvg_out_t out_data_o;
  bit quiet = 0, hold_long = 0;
  vertex_board board = new();

  sprite_quad_vertex_gen_unit u_dut (.*);

  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 6))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'(int'($urandom_range(0, 'h200000)) - 'h100000);
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic sqvg_in_t random_sprite();
    sqvg_in_t d;
    d.dst_x = pick32(); d.dst_y = pick32();
    d.dst_w = pick32(); d.dst_h = pick32();
    d.uv_start = $urandom; d.uv_size = $urandom;
    d.origin_x = pick32(); d.origin_y = pick32();
    case ($urandom_range(0, 5))
      0: d.rotation = 0;
      1: d.rotation = 16'($urandom_range(0, 3) << 14);
      2: d.rotation = 16'(($urandom_range(0, 3) << 14) + $urandom_range(0, 4) - 2);
      default: d.rotation = 16'($urandom);
    endcase
    d.effects = 2'($urandom);
    case ($urandom_range(0, 3))
      0: d.color = {8'hFF, 24'($urandom)};
      1: d.color = {8'h00, 24'($urandom)};
      default: d.color = $urandom;
    endcase
    return d;
  endfunction

  task automatic send_sprite(sqvg_in_t d);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid_i <= 1;
    in_data_i <= d;
    do @(posedge clk_i); while (in_stall_o);
    board.note_sprite(d);
  endtask

  // receiver: random stall bursts, one long hold-off on request
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_vertex(out_data_o);
  end

  initial begin : receiver
    int n;
    @(posedge rst_ni);
    forever begin
      if (hold_long) begin
        out_stall_i <= 1;
        for (n = 0; n < 200; n++) @(posedge clk_i);
        hold_long = 0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end else begin
        out_stall_i <= 0;
        @(posedge clk_i);
      end
    end
  end

  initial begin : limit
    #20000000;
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    sqvg_in_t d;
    int waited;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: zero angle, quadrants, boundary angles, extremes, flips, UV saturation, alpha cases
    for (int i = 0; i < 20; i++) begin
      d = '0;
      d.dst_w = 32'h0010_0000; d.dst_h = 32'h0008_0000;
      d.uv_start = 32'h1000_2000; d.uv_size = 32'h4000_3000;
      d.origin_x = 32'h0008_0000; d.origin_y = 32'h0004_0000;
      d.effects = 2'(i);
      d.rotation = 16'(i * 16'h4000);
      d.color = (i % 3 == 0) ? 32'hFF12_3456 : (i % 3 == 1) ? 32'h0012_3456 : 32'h80FF_8001;
      if (i >= 4 && i < 8) begin
        d.dst_x = (i & 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        d.dst_y = (i & 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        d.dst_w = 32'h7FFF_FFFF; d.dst_h = 32'h8000_0000;
        d.origin_x = (i & 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        d.origin_y = 32'hFFFF_FFFF;
      end
      if (i == 8) begin d.uv_start = 32'hFFFF_FFFF; d.uv_size = 32'hFFFF_FFFF; end
      if (i == 9) d.rotation = 16'h7FFF;
      if (i == 10) d.rotation = 16'h8000;
      if (i == 11) d.rotation = 16'h0001;
      if (i == 12) d.rotation = 16'hFFFF;
      if (i == 13) d.rotation = 16'h2000;
      if (i == 14) d.color = 32'hFFFF_FFFF;
      if (i == 15) d.color = 32'hFE00_FF7F;
      send_sprite(d);
    end
    for (int i = 0; i < 390; i++) begin
      if (i == 100) hold_long = 1;
      if (i == 330) quiet = 1;
      send_sprite(random_sprite());
    end
    in_valid_i <= 0;
    waited = 0;
    while (board.pending.size() != 0 && waited < 100000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (30) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule

FILE: sprite_quad_vertex_gen_unit.f
design/sqvg_pkg.sv
design/sqvg_prep.sv
design/sqvg_cordic.sv
design/sqvg_vertex.sv
design/sprite_quad_vertex_gen_unit.sv
dv/sprite_quad_vertex_gen_unit_test.sv
